### src/gpms_pkg.sv
// Shared types, widths and the saturating helper for the grid path block.
// No dependencies; imported by gpms_cell and grid_path_max_with_skips_top.
`timescale 1ns / 1ps
`default_nettype none
package gpms_pkg;

  localparam int COIN_W      = 16;
  localparam int SUM_W       = 32;
  localparam int CFG_W       = 10;
  localparam int SKIP_LEVELS = 3;

  typedef logic signed [COIN_W-1:0] coin_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [SUM_W:0]    wide_sum_t;

  // per-item control handed from the front end to every cell
  typedef struct packed {
    logic start;     // top-left cell: no predecessors at all
    logic has_up;
    logic has_left;
    logic bypass;    // up value is the item just written, take it from left
  } cell_ctrl_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  function automatic sum_t sat_sum(input wide_sum_t v);
    sum_t r;
    if (v > wide_sum_t'(SUM_MAX)) r = SUM_MAX;
    else if (v < wide_sum_t'(SUM_MIN)) r = SUM_MIN;
    else r = v[SUM_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### src/gpms_cell.sv
// One skip-level cell: row line store, left register and the per-cell update.
// Depends on gpms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gpms_cell #(
  parameter int MAX_COLUMNS = 512,
  parameter bit LOWEST      = 1'b0,
  parameter int IDX_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  wire                     clk,
  input  wire                     rd_en,
  input  wire  [IDX_W-1:0]        rd_addr,
  input  wire                     wr_en,
  input  wire  [IDX_W-1:0]        wr_addr,
  input  gpms_pkg::cell_ctrl_t    ctrl,
  input  gpms_pkg::coin_t         coin,
  input  gpms_pkg::sum_t          pred_in,   // predecessor of the level below
  output gpms_pkg::sum_t          pred_out,  // this level's predecessor, to the level above
  output gpms_pkg::sum_t          cur
);
  import gpms_pkg::*;

  sum_t      row_mem [MAX_COLUMNS];
  sum_t      rd_q;
  sum_t      left;
  sum_t      up;
  sum_t      pred;
  wide_sum_t total;
  wide_sum_t take;
  wide_sum_t coin_ext;

  // read-first: a same-cycle write to rd_addr is covered by ctrl.bypass
  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= row_mem[rd_addr];
    if (wr_en) begin
      row_mem[wr_addr] <= cur;
      left             <= cur;
    end
  end

  always_comb begin
    coin_ext = wide_sum_t'(coin);
    up       = ctrl.bypass ? left : rd_q;
    if (ctrl.has_up && ctrl.has_left) pred = (up > left) ? up : left;
    else if (ctrl.has_up)             pred = up;
    else                              pred = left;
    total = wide_sum_t'(pred) + coin_ext;
    take  = total;
    // negative cell: neutralising it copies the lower level's predecessor
    if (!LOWEST && coin < 0 && wide_sum_t'(pred_in) > total) take = wide_sum_t'(pred_in);
    if (ctrl.start) begin
      if (LOWEST || coin >= 0) cur = sum_t'(coin);
      else                     cur = '0;
    end else begin
      cur = sat_sum(take);
    end
    pred_out = pred;
  end

endmodule
`default_nettype wire

### src/grid_path_max_with_skips_top.sv
// Top level of the grid maximum-path block: stream ports, APB register,
// position tracking and the chain of skip-level cells. Depends on gpms_pkg, gpms_cell.
//
// Usage
//  - Input stream s_*: one grid cell per transaction, row-major order.
//    s_tdata[15:0] = coin (signed), s_tlast = last_cell (bottom-right cell).
//  - Output stream m_*: one transaction per grid, m_tdata[31:0] = amount,
//    the best right/down path sum with up to two negative cells counted as zero.
//  - APB: register columns (cells per row, 10 bits) at byte address 0.
//    Write it only while the block is idle. 0 acts as 1, above MAX_COLUMNS
//    acts as MAX_COLUMNS.
//  - Throughput: one cell per cycle while the input is not stalled. Each cell needs one
//    read of the row line store (registered) and one write; a row of one column
//    forwards the previous result from the left register.
//  - Result path: the last cell passes the stage-1 register, then the result register.
//  - Stall: a held result blocks the next last cell in stage 1 and the input behind
//    it; ordinary cells ahead of that last cell keep flowing.
//  - Reset: column position 0, first row, columns = 1, no result pending.
//    Line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module grid_path_max_with_skips_top #(
  parameter int MAX_COLUMNS = 512
) (
  input  wire         clk,
  input  wire         rst,
  // input cells
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [15:0] coin
  input  wire         s_tlast,   // last_cell
  // results
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] amount
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gpms_pkg::*;

  localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LEN_W = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam logic [CMP_W-1:0] MaxLen = CMP_W'(MAX_COLUMNS);
  localparam logic             RegColumns = 1'b0;

  // ---------------- configuration register ----------------
  logic [CFG_W-1:0] columns;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegColumns);
  assign prdata = (paddr[2] == RegColumns) ? 32'(columns) : '0;

  always_ff @(posedge clk) begin
    if (rst) columns <= CFG_W'(1);
    else if (cfg_wr) columns <= pwdata[CFG_W-1:0];
  end

  // ---------------- pipeline control ----------------
  logic             in_xfer;
  logic             s1_valid;
  logic             s1_last;
  logic             s1_fire;
  logic [IDX_W-1:0] s1_col;
  coin_t            s1_coin;
  cell_ctrl_t       s1_ctrl;

  // a last cell may retire only if the result register is free or draining
  assign s1_fire  = s1_valid && !(s1_last && m_tvalid && !m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign in_xfer  = s_tvalid && s_tready;

  // ---------------- position tracking ----------------
  logic [IDX_W-1:0] column_index;
  logic             in_first_row;
  logic [CMP_W-1:0] row_len;
  logic [CMP_W-1:0] col_plus;
  logic             row_end;

  always_comb begin
    if (columns == '0)                  row_len = CMP_W'(1);
    else if (CMP_W'(columns) > MaxLen)  row_len = MaxLen;
    else                                row_len = CMP_W'(columns);
    col_plus = CMP_W'(column_index) + CMP_W'(1);
    row_end  = col_plus >= row_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      in_first_row <= 1'b1;
      s1_valid     <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (s_tlast) begin
          column_index <= '0;
          in_first_row <= 1'b1;
        end else if (row_end) begin
          column_index <= '0;
          in_first_row <= 1'b0;
        end else begin
          column_index <= col_plus[IDX_W-1:0];
        end
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // stage-1 payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_last          <= s_tlast;
      s1_col           <= column_index;
      s1_coin          <= s_tdata[COIN_W-1:0];
      s1_ctrl.start    <= in_first_row && (column_index == '0);
      s1_ctrl.has_up   <= !in_first_row;
      s1_ctrl.has_left <= column_index != '0;
      s1_ctrl.bypass   <= s1_fire && (s1_col == column_index);
    end
  end

  // ---------------- chain of skip-level cells ----------------
  sum_t pred_chain [SKIP_LEVELS+1];
  sum_t cur_lvl    [SKIP_LEVELS];

  assign pred_chain[0] = '0;

  for (genvar k = 0; k < SKIP_LEVELS; k++) begin : g_level
    gpms_cell #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .LOWEST     (k == 0)
    ) u_cell (
      .clk     (clk),
      .rd_en   (in_xfer),
      .rd_addr (column_index),
      .wr_en   (s1_fire),
      .wr_addr (s1_col),
      .ctrl    (s1_ctrl),
      .coin    (s1_coin),
      .pred_in (pred_chain[k]),
      .pred_out(pred_chain[k+1]),
      .cur     (cur_lvl[k])
    );
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) m_tdata <= cur_lvl[SKIP_LEVELS-1];
  end

  // ---------------- assertions ----------------
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(s1_fire && s1_last))
    else $error("pending result overwritten");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_fire && s1_last))
    else $error("result raised without a last cell");

  a_stage_load: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid)
    else $error("accepted transaction lost");

  a_grid_restart: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tlast) |=> (in_first_row && column_index == '0))
    else $error("position not reset after last cell");

endmodule
`default_nettype wire
